@@ hdl/mnds_pkg.sv @@
package mnds_pkg;

  localparam int unsigned NoteW = 7;
  localparam int unsigned ModeW = 2;

  localparam logic [ModeW-1:0] MODE_PLAY = 2'd0;
  localparam logic [ModeW-1:0] MODE_STOP = 2'd1;
  localparam logic [ModeW-1:0] MODE_TICK = 2'd2;

  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [NoteW-1:0] pitch;
    logic [NoteW-1:0] note_length;
    logic [NoteW-1:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic             message_kind;
    logic [NoteW-1:0] note_number;
    logic [NoteW-1:0] note_velocity;
    logic             untracked;
    logic             last_message;
  } out_item_t;

  // one slot entry in the table memory
  typedef struct packed {
    logic [NoteW-1:0] pitch;
    logic [NoteW-1:0] remaining;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAY,
    ST_STOP,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_FLUSH
  } state_e;

endpackage

@@ hdl/midi_note_duration_scheduler.sv @@
// Channel  | Direction | Handshake              | Payload
// input    | in        | in_valid_i/in_stall_o  | in_data_i  (mnds_pkg::in_item_t)
// output   | out       | out_valid_o/out_stall_i| out_data_o (mnds_pkg::out_item_t)
//
// One item at a time. Play scans the active bits one slot per cycle for the lowest
// free slot. A tick reads one slot of the table memory per cycle, unless a released
// note-off waits on a stalled output.
// Reset clears all active bits at once; no clearing pass is needed.
// A stalled output holds the block while it has a result to load and the output register is full.
module midi_note_duration_scheduler #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mnds_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mnds_pkg::out_item_t  out_data_o
);
  import mnds_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  state_e state_q, state_d;
  in_item_t item_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [NUM_SLOTS-1:0] active_q;

  slot_t mem_q [NUM_SLOTS];
  slot_t rd_q;
  logic mem_we, mem_re;
  logic [IdxW-1:0] mem_wa, mem_ra;
  slot_t mem_wd;

  logic out_valid_q;
  out_item_t out_q, out_d;
  logic out_load;

  logic pend_vld_q, pend_vld_d;
  logic [NoteW-1:0] pend_pitch_q;
  logic pend_load;

  logic act_set, act_clr;
  logic in_acc, out_free, idx_last, slot_act, release_slot, ev_wait;

  assign in_acc = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_last = (idx_q == LastIdx);
  assign slot_act = active_q[idx_q];
  assign release_slot = slot_act && (rd_q.remaining <= NoteW'(1));
  assign ev_wait = release_slot && pend_vld_q && !out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.mode)
            MODE_PLAY: state_d = ST_PLAY;
            MODE_STOP: state_d = ST_STOP;
            MODE_TICK: state_d = ST_TICK_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_PLAY: begin
        if ((!slot_act || idx_last) && out_free) state_d = ST_IDLE;
      end
      ST_STOP: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_TICK_RD: state_d = ST_TICK_EV;
      ST_TICK_EV: begin
        if (!ev_wait && idx_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_vld_q || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    idx_d      = idx_q;
    mem_we     = 1'b0;
    mem_wa     = idx_q;
    mem_wd     = rd_q;
    mem_re     = 1'b0;
    mem_ra     = idx_q;
    out_load   = 1'b0;
    out_d      = out_q;
    pend_load  = 1'b0;
    pend_vld_d = pend_vld_q;
    act_set    = 1'b0;
    act_clr    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) idx_d = '0;
      end
      ST_PLAY: begin
        if (slot_act && !idx_last) begin
          idx_d = idx_q + IdxW'(1);
        end else if (out_free) begin
          out_load            = 1'b1;
          out_d.message_kind  = KIND_ON;
          out_d.note_number   = item_q.pitch;
          out_d.note_velocity = item_q.velocity;
          out_d.untracked     = slot_act;
          out_d.last_message  = 1'b1;
          if (!slot_act) begin
            act_set          = 1'b1;
            mem_we           = 1'b1;
            mem_wd.pitch     = item_q.pitch;
            mem_wd.remaining = item_q.note_length;
          end
        end
      end
      ST_STOP: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_d.message_kind  = KIND_OFF;
          out_d.note_number   = item_q.pitch;
          out_d.note_velocity = '0;
          out_d.untracked     = 1'b0;
          out_d.last_message  = 1'b1;
        end
      end
      ST_TICK_RD: begin
        mem_re = 1'b1;
      end
      ST_TICK_EV: begin
        if (!ev_wait) begin
          if (release_slot) begin
            act_clr    = 1'b1;
            pend_load  = 1'b1;
            pend_vld_d = 1'b1;
            // push the previous note-off, it is not the final one
            if (pend_vld_q) begin
              out_load            = 1'b1;
              out_d.message_kind  = KIND_OFF;
              out_d.note_number   = pend_pitch_q;
              out_d.note_velocity = '0;
              out_d.untracked     = 1'b0;
              out_d.last_message  = 1'b0;
            end
          end else if (slot_act) begin
            mem_we           = 1'b1;
            mem_wd.remaining = rd_q.remaining - NoteW'(1);
          end
          if (!idx_last) begin
            idx_d  = idx_q + IdxW'(1);
            mem_re = 1'b1;
            mem_ra = idx_q + IdxW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (pend_vld_q && out_free) begin
          out_load            = 1'b1;
          out_d.message_kind  = KIND_OFF;
          out_d.note_number   = pend_pitch_q;
          out_d.note_velocity = '0;
          out_d.untracked     = 1'b0;
          out_d.last_message  = 1'b1;
          pend_vld_d          = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      pend_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      pend_vld_q <= pend_vld_d;
      if (act_set) active_q[idx_q] <= 1'b1;
      if (act_clr) active_q[idx_q] <= 1'b0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    if (out_load) out_q <= out_d;
    if (pend_load) pend_pitch_q <= rd_q.pitch;
  end

  // slot table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem_q[mem_ra];
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pend_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (state_q == ST_TICK_EV || state_q == ST_FLUSH))
    else $error("pending note-off outside a tick");

  a_play_claims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLAY && out_free && !slot_act) |=> active_q[$past(idx_q)])
    else $error("tracked note-on did not claim its slot");

  a_on_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.message_kind == KIND_ON) |-> out_data_o.last_message)
    else $error("note-on not marked final");

  a_off_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.message_kind == KIND_OFF)
      |-> (out_data_o.note_velocity == '0 && !out_data_o.untracked))
    else $error("note-off with velocity or untracked flag");

endmodule

@@ sim/mnds_checker.sv @@
`timescale 1ns / 100ps

module mnds_checker #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  mnds_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  mnds_pkg::out_item_t out_data_i,
  output int                  fails_o,
  output int                  pending_o
);
  import mnds_pkg::*;

  logic             slot_busy [NUM_SLOTS];
  logic [NoteW-1:0] slot_note [NUM_SLOTS];
  logic [NoteW-1:0] slot_left [NUM_SLOTS];
  out_item_t        midi_msgs_q [$];
  int               mismatches = 0;

  assign fails_o = mismatches;

  function automatic out_item_t midi_msg(logic kind, logic [NoteW-1:0] note,
                                         logic [NoteW-1:0] vel, logic untr, logic last);
    out_item_t m;
    m.message_kind  = kind;
    m.note_number   = note;
    m.note_velocity = vel;
    m.untracked     = untr;
    m.last_message  = last;
    return m;
  endfunction

  function automatic string show(out_item_t m);
    return $sformatf("kind=%0d note=%0d vel=%0d untracked=%0d last=%0d",
                     m.message_kind, m.note_number, m.note_velocity,
                     m.untracked, m.last_message);
  endfunction

  // Update the slot table for one transaction and queue the MIDI messages it causes.
  task automatic predict_midi_msgs(in_item_t it);
    int free_idx;
    int last_off;
    free_idx = -1;
    last_off = -1;
    case (it.mode)
      MODE_PLAY: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (!slot_busy[i] && free_idx < 0) free_idx = i;
        if (free_idx >= 0) begin
          slot_busy[free_idx] = 1'b1;
          slot_note[free_idx] = it.pitch;
          slot_left[free_idx] = it.note_length;
        end
        midi_msgs_q.push_back(midi_msg(KIND_ON, it.pitch, it.velocity, free_idx < 0, 1'b1));
      end
      MODE_STOP: begin
        midi_msgs_q.push_back(midi_msg(KIND_OFF, it.pitch, '0, 1'b0, 1'b1));
      end
      MODE_TICK: begin
        // find the highest slot released so its note-off carries the last mark
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_busy[i] && slot_left[i] <= 1) last_off = i;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_busy[i]) begin
            if (slot_left[i] <= 1) begin
              midi_msgs_q.push_back(midi_msg(KIND_OFF, slot_note[i], '0, 1'b0, i == last_off));
              slot_busy[i] = 1'b0;
            end else begin
              slot_left[i] = slot_left[i] - 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t exp_msg;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) slot_busy[i] = 1'b0;
      midi_msgs_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_midi_msgs(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (midi_msgs_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected MIDI message: expected none, got %s",
                   $time, show(out_data_i));
        end else begin
          exp_msg = midi_msgs_q.pop_front();
          if (exp_msg !== out_data_i) begin
            mismatches++;
            $display("%0t: MIDI message mismatch: expected %s, got %s",
                     $time, show(exp_msg), show(out_data_i));
          end
        end
      end
      pending_o <= midi_msgs_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import mnds_pkg::*;

  localparam int unsigned NUM_SLOTS  = 64;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned MIX_ITEMS  = 180;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  int fails;
  int pending_cnt;
  bit quiet_in    = 1'b0;
  int stall_left  = 0;
  int calm_left   = 0;
  int idle_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  midi_note_duration_scheduler #(
    .NUM_SLOTS (NUM_SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  mnds_checker #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fails_o     (fails),
    .pending_o   (pending_cnt)
  );

  // Output backpressure: short stalls mostly, a few long ones, and calm runs with none.
  always @(posedge clk_i) begin : backpressure
    int r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) calm_left = $urandom_range(40, 200);
      else if (r < 46) stall_left = $urandom_range(1, 3);
      else if (r < 50) stall_left = $urandom_range(15, 40);
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_item_t note_item(logic [ModeW-1:0] mode, logic [NoteW-1:0] pitch,
                                         logic [NoteW-1:0] len, logic [NoteW-1:0] vel);
    in_item_t it;
    it.mode        = mode;
    it.pitch       = pitch;
    it.note_length = len;
    it.velocity    = vel;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_in || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly short notes so ticks keep releasing slots; a few long ones.
  function automatic in_item_t random_item();
    int r;
    int l;
    logic [ModeW-1:0] mode;
    r = $urandom_range(0, 99);
    if (r < 40) mode = MODE_PLAY;
    else if (r < 55) mode = MODE_STOP;
    else if (r < 95) mode = MODE_TICK;
    else mode = MODE_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 70) l = $urandom_range(0, 6);
    else if (r < 90) l = $urandom_range(7, 30);
    else l = $urandom_range(31, 127);
    return note_item(mode, NoteW'($urandom_range(0, 127)), NoteW'(l),
                     NoteW'($urandom_range(0, 127)));
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold the input until every predicted message has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(note_item(MODE_PLAY, 7'd0, 7'd0, 7'd0));
    send_item(note_item(MODE_PLAY, 7'd127, 7'd127, 7'd127));
    send_item(note_item(MODE_PLAY, 7'd60, 7'd1, 7'd64));
    send_item(note_item(MODE_PLAY, 7'd61, 7'd2, 7'd1));
    send_item(note_item(MODE_STOP, 7'd0, 7'd127, 7'd127));
    send_item(note_item(MODE_STOP, 7'd127, 7'd0, 7'd0));
    send_item(note_item(MODE_UNUSED, 7'd127, 7'd127, 7'd127));
    send_item(note_item(MODE_TICK, 7'd0, 7'd0, 7'd0));
    send_item(note_item(MODE_TICK, 7'd127, 7'd127, 7'd127));
    send_item(note_item(MODE_TICK, 7'd33, 7'd5, 7'd9));
    send_item(note_item(MODE_PLAY, 7'd5, 7'd3, 7'd100));
    send_item(note_item(MODE_STOP, 7'd5, 7'd3, 7'd0));
    send_item(note_item(MODE_UNUSED, 7'd0, 7'd0, 7'd0));

    // Fill the table back to back, overflow it, then release nearly all slots at once.
    quiet_in = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++)
      send_item(note_item(MODE_PLAY, NoteW'($urandom_range(0, 127)),
                          NoteW'($urandom_range(0, 1)), NoteW'($urandom_range(0, 127))));
    quiet_in = 1'b0;
    send_item(note_item(MODE_TICK, 7'd0, 7'd0, 7'd0));
    wait_drained();

    for (int i = 0; i < MIX_ITEMS; i++) begin
      if ($urandom_range(0, 49) == 0) wait_drained();
      send_item(random_item());
    end

    wait_drained();
    repeat (NUM_SLOTS + 10) @(posedge clk_i);
    if (fails == 0 && pending_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
